// ===== rtl/ple_pkg.sv =====
// Package for the positional list engine: command, status and state codes,
// plus the control and status bundles shared by controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_POS   = 3'd4,
        CMD_DEL_END   = 3'd5,
        CMD_SEARCH    = 3'd6,
        CMD_SORT      = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_BAD_POS    = 2'd1,
        ST_FULL_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SORT,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH,
        OP_SORT_INIT,
        OP_SORT_STEP
    } dp_op_t;

    typedef enum logic [1:0] {
        AT_FRONT,
        AT_END,
        AT_POS
    } where_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t  op;
        where_t  where;
        logic    load_res;
        status_t res_status;
        logic    res_use_hit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_above;
        logic pos_past_end;
        logic sort_done;
    } dp_stat_t;

endpackage

// ===== rtl/ple_datapath.sv =====
// Datapath of the positional list engine: element registers with shifting
// insert/delete, parallel search hits, odd-even sort network and result register.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_datapath #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic signed [ple_pkg::VALUE_W-1:0]     s_value,
    input  logic        [ple_pkg::POS_W-1:0]       s_position,
    input  logic                                   s_ascending_order,
    input  ple_pkg::dp_cmd_t                       cmd,
    output ple_pkg::dp_stat_t                      stat,
    output ple_pkg::status_t                       m_status,
    output logic                                   m_found,
    output logic        [ple_pkg::COUNT_W-1:0]     m_entry_count
);
    import ple_pkg::*;

    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic signed [VALUE_W-1:0] store_reg  [LIST_DEPTH];
    logic signed [VALUE_W-1:0] store_next [LIST_DEPTH];
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             pass_reg, pass_next;
    logic                      phase_reg, phase_next;
    logic                      asc_reg, asc_next;
    logic [LIST_DEPTH-1:0]     hit_reg, hit_next;
    status_t                   status_reg;
    logic                      found_reg;
    logic [COUNT_W-1:0]        entry_count_reg;

    logic [CMPW-1:0]           count_ext, count_next_ext, pos_ext, idx;
    logic                      swap;

    // widen count and position to a common compare width
    assign count_ext      = CMPW'(count_reg);
    assign count_next_ext = CMPW'(count_next);
    assign pos_ext        = CMPW'(s_position);

    // status towards the controller
    assign stat.full         = (count_reg >= CW'(LIST_DEPTH));
    assign stat.empty        = (count_reg == '0);
    assign stat.pos_above    = (pos_ext > count_ext);
    assign stat.pos_past_end = (pos_ext >= count_ext);
    assign stat.sort_done    = (pass_reg >= count_reg);

    // pick the slot the request works on
    always_comb begin
        unique case (cmd.where)
            AT_FRONT: idx = '0;
            AT_END:   idx = (cmd.op == OP_DELETE) ? (count_ext - CMPW'(1)) : count_ext;
            default:  idx = pos_ext;
        endcase
    end

    // next contents of the element registers and bookkeeping
    always_comb begin
        store_next = store_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        phase_next = phase_reg;
        asc_next   = asc_reg;
        hit_next   = hit_reg;
        swap       = 1'b0;
        case (cmd.op)
            OP_INSERT: begin
                for (int i = 1; i < LIST_DEPTH; i++) begin
                    if (CMPW'(i) > idx) store_next[i] = store_reg[i-1];
                end
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    if (CMPW'(i) == idx) store_next[i] = s_value;
                end
                count_next = count_reg + CW'(1);
            end
            OP_DELETE: begin
                for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                    if (CMPW'(i) >= idx) store_next[i] = store_reg[i+1];
                end
                count_next = count_reg - CW'(1);
            end
            OP_SEARCH: begin
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    hit_next[i] = (CMPW'(i) < count_ext) && (store_reg[i] == s_value);
                end
            end
            OP_SORT_INIT: begin
                pass_next  = '0;
                phase_next = 1'b0;
                asc_next   = s_ascending_order;
            end
            OP_SORT_STEP: begin
                // compare-exchange every pair of this phase that lies inside the list
                for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                    swap = asc_reg ? (store_reg[i] > store_reg[i+1])
                                   : (store_reg[i] < store_reg[i+1]);
                    if ((i % 2 == 1) == phase_reg && CMPW'(i + 1) < count_ext && swap) begin
                        store_next[i]   = store_reg[i+1];
                        store_next[i+1] = store_reg[i];
                    end
                end
                pass_next  = pass_reg + CW'(1);
                phase_next = ~phase_reg;
            end
            default: ;
        endcase
    end

    // element registers and sort/search scratch: no reset needed
    always_ff @(posedge aclk) begin
        store_reg <= store_next;
        pass_reg  <= pass_next;
        phase_reg <= phase_next;
        asc_reg   <= asc_next;
        hit_reg   <= hit_next;
    end

    // element count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_res) begin
            status_reg      <= cmd.res_status;
            found_reg       <= cmd.res_use_hit & (|hit_reg);
            entry_count_reg <= count_next_ext[COUNT_W-1:0];
        end
    end

    assign m_status      = status_reg;
    assign m_found       = found_reg;
    assign m_entry_count = entry_count_reg;

endmodule

// ===== rtl/ple_ctrl.sv =====
// Controller of the positional list engine: request decode, status checks
// and sequencing of search, sort and result handshake. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ple_pkg::cmd_t      s_command,
    output logic               m_valid,
    input  logic               m_ready,
    input  ple_pkg::dp_stat_t  stat,
    output ple_pkg::dp_cmd_t   cmd
);
    import ple_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next      = state_reg;
        cmd.op          = OP_NONE;
        cmd.where       = AT_POS;
        cmd.load_res    = 1'b0;
        cmd.res_status  = ST_DONE;
        cmd.res_use_hit = 1'b0;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next   = S_RESP;
                    cmd.load_res = 1'b1;
                    unique case (s_command)
                        CMD_INS_FRONT, CMD_INS_END: begin
                            cmd.where = (s_command == CMD_INS_FRONT) ? AT_FRONT : AT_END;
                            if (stat.full) cmd.res_status = ST_FULL_EMPTY;
                            else           cmd.op         = OP_INSERT;
                        end
                        CMD_INS_POS: begin
                            if (stat.pos_above) cmd.res_status = ST_BAD_POS;
                            else if (stat.full) cmd.res_status = ST_FULL_EMPTY;
                            else                cmd.op         = OP_INSERT;
                        end
                        CMD_DEL_FRONT, CMD_DEL_END: begin
                            cmd.where = (s_command == CMD_DEL_FRONT) ? AT_FRONT : AT_END;
                            if (stat.empty) cmd.res_status = ST_FULL_EMPTY;
                            else            cmd.op         = OP_DELETE;
                        end
                        CMD_DEL_POS: begin
                            if (stat.empty)             cmd.res_status = ST_FULL_EMPTY;
                            else if (stat.pos_past_end) cmd.res_status = ST_BAD_POS;
                            else                        cmd.op         = OP_DELETE;
                        end
                        CMD_SEARCH: begin
                            // capture hit vector, load the result from it in S_SEARCH
                            cmd.op       = OP_SEARCH;
                            cmd.load_res = 1'b0;
                            state_next   = S_SEARCH;
                        end
                        default: begin
                            cmd.op       = OP_SORT_INIT;
                            cmd.load_res = 1'b0;
                            state_next   = S_SORT;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                cmd.load_res    = 1'b1;
                cmd.res_use_hit = 1'b1;
                state_next      = S_RESP;
            end
            S_SORT: begin
                // one odd-even pass per cycle until count passes are done
                if (stat.sort_done) begin
                    cmd.load_res = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    cmd.op = OP_SORT_STEP;
                end
            end
            S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: one request at a time, one result per request.
// m_valid rises in the cycle after accept for insert, delete and rejected
// requests; search first registers the hit vector, then the result; sort
// runs count odd-even compare-exchange passes, one pass per cycle, then
// loads the result. A new request is taken once the result is taken.
// Synchronous active-low reset empties the list; element contents are kept.
`timescale 1ns / 1ps

module positional_list_engine #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [ple_pkg::CMD_W-1:0]   s_command,
    input  logic signed [ple_pkg::VALUE_W-1:0] s_value,
    input  logic        [ple_pkg::POS_W-1:0]   s_position,
    input  logic                               s_ascending_order,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [ple_pkg::STATUS_W-1:0] m_status,
    output logic                               m_found,
    output logic        [ple_pkg::COUNT_W-1:0] m_entry_count
);
    import ple_pkg::*;

    dp_cmd_t dp_cmd;
    dp_stat_t dp_stat;
    status_t status;

    // controller
    ple_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (cmd_t'(s_command)),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // datapath
    ple_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_value           (s_value),
        .s_position        (s_position),
        .s_ascending_order (s_ascending_order),
        .cmd               (dp_cmd),
        .stat              (dp_stat),
        .m_status          (status),
        .m_found           (m_found),
        .m_entry_count     (m_entry_count)
    );

    assign m_status = status;

endmodule

// ===== bench/tb_positional_list_engine.sv =====
// Self-checking bench for positional_list_engine: directed and random list requests,
// with a scoreboard class that mirrors the list and checks every result in order.
// Depends on rtl/ple_pkg.sv and rtl/positional_list_engine.sv.
`timescale 1ns / 1ps

module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int  LIST_DEPTH  = 16;
    localparam int  PHASE_ITEMS = 225;
    localparam int  DRAIN_LIMIT = 5000;
    localparam time RUN_LIMIT   = 2_000_000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_command = CMD_SEARCH;
    logic signed [VALUE_W-1:0]  s_value = '0;
    logic [POS_W-1:0]           s_position = '0;
    logic                       s_ascending_order = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic                       m_found;
    logic [COUNT_W-1:0]         m_entry_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit growing        = 1'b1;

    // Mirror of the list contents; predicts one result per accepted request
    class list_scoreboard;
        typedef struct {
            status_t            status;
            logic               found;
            logic [COUNT_W-1:0] count;
        } list_result_t;

        logic signed [VALUE_W-1:0] elems[LIST_DEPTH];
        int unsigned               held;
        list_result_t              awaited[$];
        int                        errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void open_gap(int unsigned at, logic signed [VALUE_W-1:0] v);
            for (int unsigned i = held; i > at; i--) elems[i] = elems[i-1];
            elems[at] = v;
            held++;
        endfunction

        function void close_gap(int unsigned at);
            for (int unsigned i = at; i + 1 < held; i++) elems[i] = elems[i+1];
            held--;
        endfunction

        // Apply one request to the mirror and queue the result it should give
        function void note_request(cmd_t cmd, logic signed [VALUE_W-1:0] v,
                                   logic [POS_W-1:0] pos, logic asc);
            list_result_t              res;
            logic signed [VALUE_W-1:0] key;
            int                        j;
            bit                        full;
            bit                        empty;
            full       = (held >= LIST_DEPTH);
            empty      = (held == 0);
            res.status = ST_DONE;
            res.found  = 1'b0;
            case (cmd)
                CMD_INS_FRONT: begin
                    if (full) res.status = ST_FULL_EMPTY; else open_gap(0, v);
                end
                CMD_INS_END: begin
                    if (full) res.status = ST_FULL_EMPTY; else open_gap(held, v);
                end
                CMD_INS_POS: begin
                    // position check comes before the full check
                    if (pos > held) res.status = ST_BAD_POS;
                    else if (full) res.status = ST_FULL_EMPTY;
                    else open_gap(pos, v);
                end
                CMD_DEL_FRONT: begin
                    if (empty) res.status = ST_FULL_EMPTY; else close_gap(0);
                end
                CMD_DEL_POS: begin
                    if (empty) res.status = ST_FULL_EMPTY;
                    else if (pos >= held) res.status = ST_BAD_POS;
                    else close_gap(pos);
                end
                CMD_DEL_END: begin
                    if (empty) res.status = ST_FULL_EMPTY; else held--;
                end
                CMD_SEARCH: begin
                    for (int unsigned i = 0; i < held; i++)
                        if (elems[i] == v) res.found = 1'b1;
                end
                default: begin
                    // insertion sort in the requested direction
                    for (int i = 1; i < int'(held); i++) begin
                        key = elems[i];
                        j   = i;
                        while (j > 0 && (asc ? (elems[j-1] > key) : (key > elems[j-1]))) begin
                            elems[j] = elems[j-1];
                            j--;
                        end
                        elems[j] = key;
                    end
                end
            endcase
            res.count = held[COUNT_W-1:0];
            awaited.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Compare one delivered result against the oldest expectation
        task check_result(logic [STATUS_W-1:0] st, logic f, logic [COUNT_W-1:0] cnt);
            list_result_t exp_res;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d found=%0d count=%0d",
                                          st, f, cnt));
                return;
            end
            exp_res = awaited.pop_front();
            if (st !== exp_res.status)
                report_mismatch($sformatf("status %0d, want %0d", st, exp_res.status));
            if (f !== exp_res.found)
                report_mismatch($sformatf("found %0d, want %0d", f, exp_res.found));
            if (cnt !== exp_res.count)
                report_mismatch($sformatf("entry_count %0d, want %0d", cnt, exp_res.count));
        endtask
    endclass

    list_scoreboard sb = new();

    positional_list_engine #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_value           (s_value),
        .s_position        (s_position),
        .s_ascending_order (s_ascending_order),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_found           (m_found),
        .m_entry_count     (m_entry_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_status, m_found, m_entry_count);
    end

    // Present one request at a falling edge and hold it until accepted
    task automatic drive_request(cmd_t cmd, logic signed [VALUE_W-1:0] v,
                                 logic [POS_W-1:0] pos, logic asc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_value           <= v;
        s_position        <= pos;
        s_ascending_order <= asc;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, v, pos, asc);
        @(negedge aclk);
    endtask

    // Mix of extremes, a narrow band for duplicates, and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            case ($urandom_range(4))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (r < 65) return $signed($urandom_range(16)) - 32'sd8;
        return $signed($urandom());
    endfunction

    // Build one random request, drifting the list between empty and full
    task automatic random_request();
        cmd_t                      cmd;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0]          pos;
        int                        r;
        int unsigned               n;
        n = sb.held;
        if ((n == LIST_DEPTH && growing && $urandom_range(3) == 0) ||
            (n == 0 && !growing && $urandom_range(3) == 0) || $urandom_range(99) < 3)
            growing = !growing;
        r = $urandom_range(99);
        if (growing) begin
            if (r < 18)      cmd = CMD_INS_FRONT;
            else if (r < 36) cmd = CMD_INS_END;
            else if (r < 56) cmd = CMD_INS_POS;
            else if (r < 62) cmd = CMD_DEL_FRONT;
            else if (r < 68) cmd = CMD_DEL_POS;
            else if (r < 74) cmd = CMD_DEL_END;
            else if (r < 88) cmd = CMD_SEARCH;
            else             cmd = CMD_SORT;
        end else begin
            if (r < 6)       cmd = CMD_INS_FRONT;
            else if (r < 12) cmd = CMD_INS_END;
            else if (r < 18) cmd = CMD_INS_POS;
            else if (r < 36) cmd = CMD_DEL_FRONT;
            else if (r < 56) cmd = CMD_DEL_POS;
            else if (r < 74) cmd = CMD_DEL_END;
            else if (r < 88) cmd = CMD_SEARCH;
            else             cmd = CMD_SORT;
        end
        v = pick_value();
        if (cmd == CMD_SEARCH && n > 0 && $urandom_range(99) < 60)
            v = sb.elems[$urandom_range(n - 1)];
        pos = POS_W'($urandom_range(31));
        if (cmd == CMD_INS_POS && $urandom_range(99) < 85)
            pos = POS_W'($urandom_range(n));
        else if (cmd == CMD_DEL_POS && n > 0 && $urandom_range(99) < 85)
            pos = POS_W'($urandom_range(n - 1));
        drive_request(cmd, v, pos, 1'($urandom_range(1)));
    endtask

    // Hard stop in case the block hangs
    initial begin
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int guard;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty-list rejections, bad positions, extremes, both sorts
        drive_request(CMD_DEL_FRONT, 32'sd5, 5'd0, 1'b0);
        drive_request(CMD_DEL_END, 32'sd5, 5'd0, 1'b0);
        drive_request(CMD_DEL_POS, 32'sd5, 5'd31, 1'b0);
        drive_request(CMD_SEARCH, 32'sd0, 5'd0, 1'b0);
        drive_request(CMD_SORT, 32'sd0, 5'd0, 1'b1);
        drive_request(CMD_INS_POS, 32'sd7, 5'd1, 1'b0);
        drive_request(CMD_INS_POS, 32'sh8000_0000, 5'd0, 1'b0);
        drive_request(CMD_INS_FRONT, 32'sh7fff_ffff, 5'd0, 1'b1);
        drive_request(CMD_INS_END, -32'sd1, 5'd0, 1'b0);
        drive_request(CMD_INS_POS, 32'sd9, 5'd31, 1'b0);
        drive_request(CMD_INS_POS, 32'sd0, 5'd3, 1'b0);
        drive_request(CMD_DEL_POS, 32'sd0, 5'd4, 1'b0);
        drive_request(CMD_SEARCH, 32'sh8000_0000, 5'd0, 1'b0);
        drive_request(CMD_SEARCH, 32'sd12345, 5'd0, 1'b0);
        drive_request(CMD_SORT, 32'sd0, 5'd0, 1'b1);
        drive_request(CMD_SORT, 32'sd0, 5'd0, 1'b0);
        drive_request(CMD_DEL_POS, 32'sd0, 5'd1, 1'b0);
        drive_request(CMD_DEL_END, 32'sd0, 5'd0, 1'b0);
        drive_request(CMD_DEL_FRONT, 32'sd0, 5'd0, 1'b0);
        drive_request(CMD_DEL_POS, 32'sd0, 5'd0, 1'b0);
        drive_request(CMD_SEARCH, -32'sd1, 5'd0, 1'b0);

        // Random: no idling, idle sender, stalling receiver, then both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 36 : 0;
            recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 36 : 0;
            repeat (PHASE_ITEMS) random_request();
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then allow for a trailing sort
        guard = 0;
        while (sb.awaited.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (2 * LIST_DEPTH + 4) @(posedge aclk);
        if (sb.awaited.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
